// File: design/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and constants of the piecewise linear lookup table.
// ----------------------------------------------------------------------------
package plt_pkg;

   localparam int DATA_WIDTH        = 32;
   localparam int TABLE_ENTRIES_DEF = 64;

   typedef enum logic [1:0] {
      REQ_ADD     = 2'd0,
      REQ_INTERP  = 2'd1,
      REQ_NEAREST = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_OVERWRITE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SCAN_END,
      S_SHIFT_CHK,
      S_SHIFT_WR,
      S_NEAR,
      S_DIV_START,
      S_DIV_WAIT,
      S_FINISH
   } ctrl_state_type;

   typedef enum logic [1:0] {
      DIV_ADD,
      DIV_SUB1,
      DIV_SUB2
   } div_phase_type;

   typedef struct packed {
      logic [1:0]                   req_type;
      logic signed [DATA_WIDTH-1:0] key_x;
      logic signed [DATA_WIDTH-1:0] entry_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result_y;
      logic [1:0]                   status;
      logic                         clamped;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic set_empty;
      logic rd_cur;
      logic step;
      logic found_up;
      logic first_clamp;
      logic end_clamp;
      logic set_full;
      logic overwrite;
      logic load_shift;
      logic shift_rd;
      logic shift_wr;
      logic insert;
      logic near;
      logic div_start;
      logic div_finish;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       count_zero;
      logic       full;
      logic       idx_eq_count;
      logic       idx_zero;
      logic       idx_eq_pos;
      logic       key_gt;
      logic       key_eq;
      logic       div_done;
   } dp_status_type;

endpackage

// File: design/plt_ram.sv
// ----------------------------------------------------------------------------
// plt_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module plt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/plt_muldiv.sv
// ----------------------------------------------------------------------------
// plt_muldiv
// Bit-serial floor(a * b / d) for b < d, one bit of a per add, subtract, subtract pass.
// ----------------------------------------------------------------------------
module plt_muldiv
   import plt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] mag,
   input  logic [DATA_WIDTH-1:0] num,
   input  logic [DATA_WIDTH-1:0] den,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] quot
);

   localparam int CNTW = $clog2(DATA_WIDTH);

   logic                  busy_ff;
   logic                  done_ff;
   div_phase_type         phase_ff;
   logic [CNTW-1:0]       cnt_ff;
   logic [DATA_WIDTH-1:0] a_ff;
   logic [DATA_WIDTH-1:0] b_ff;
   logic [DATA_WIDTH-1:0] d_ff;
   logic [DATA_WIDTH+1:0] r_ff;
   logic [DATA_WIDTH-1:0] q_ff;

   logic [DATA_WIDTH+1:0] r_shift;
   logic [DATA_WIDTH+1:0] r_sub;
   logic                  r_ge;

   always_comb begin
      r_shift = {r_ff[DATA_WIDTH:0], 1'b0}
              + (a_ff[DATA_WIDTH-1] ? {2'b00, b_ff} : '0);
      r_ge    = r_ff >= {2'b00, d_ff};
      r_sub   = r_ff - {2'b00, d_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= DIV_ADD;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            phase_ff <= DIV_ADD;
            cnt_ff   <= '0;
            a_ff     <= mag;
            b_ff     <= num;
            d_ff     <= den;
            r_ff     <= '0;
            q_ff     <= '0;
         end else if (busy_ff) begin
            case (phase_ff)
               DIV_ADD: begin
                  r_ff     <= r_shift;
                  q_ff     <= {q_ff[DATA_WIDTH-2:0], 1'b0};
                  a_ff     <= {a_ff[DATA_WIDTH-2:0], 1'b0};
                  phase_ff <= DIV_SUB1;
               end
               DIV_SUB1: begin
                  if (r_ge) begin
                     r_ff <= r_sub;
                     q_ff <= q_ff + DATA_WIDTH'(1);
                  end
                  phase_ff <= DIV_SUB2;
               end
               DIV_SUB2: begin
                  if (r_ge) begin
                     r_ff <= r_sub;
                     q_ff <= q_ff + DATA_WIDTH'(1);
                  end
                  phase_ff <= DIV_ADD;
                  if (cnt_ff == CNTW'(DATA_WIDTH - 1)) begin
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end else begin
                     cnt_ff <= cnt_ff + CNTW'(1);
                  end
               end
               default: begin
                  phase_ff <= DIV_ADD;
               end
            endcase
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// File: design/plt_dp.sv
// ----------------------------------------------------------------------------
// plt_dp
// Datapath: key and value memories, scan index, neighbor registers, result.
// ----------------------------------------------------------------------------
module plt_dp
   import plt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_cmd_type    cmd,
   input  req_payload_type req_payload,
   output dp_status_type   status,
   output rsp_payload_type rsp_payload
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = AW + 1;
   localparam int DW = DATA_WIDTH;

   logic [1:0]           kind_ff;
   logic signed [DW-1:0] x_ff;
   logic signed [DW-1:0] v_ff;
   logic [CW-1:0]        idx_ff;
   logic [CW-1:0]        pos_ff;
   logic [CW-1:0]        count_ff;
   logic signed [DW-1:0] klo_ff;
   logic signed [DW-1:0] vlo_ff;
   logic signed [DW-1:0] kup_ff;
   logic signed [DW-1:0] vup_ff;
   logic signed [DW-1:0] res_y_ff;
   status_type           res_status_ff;
   logic                 res_clamped_ff;
   rsp_payload_type      out_ff;

   logic [CW-1:0]        idx_dec;
   logic [AW-1:0]        raddr;
   logic [DW-1:0]        rd_key_raw;
   logic [DW-1:0]        rd_val_raw;
   logic signed [DW-1:0] rd_key;
   logic signed [DW-1:0] rd_val;
   logic                 key_we;
   logic                 val_we;
   logic [DW-1:0]        key_wdata;
   logic [DW-1:0]        val_wdata;

   logic signed [DW:0]   dx_s;
   logic signed [DW:0]   dk_s;
   logic signed [DW:0]   dup_s;
   logic signed [DW:0]   dy_s;
   logic signed [DW:0]   mag_s;
   logic                 dy_neg;
   logic [DW-1:0]        div_q;
   logic                 div_done;

   always_comb begin
      idx_dec   = idx_ff - CW'(1);
      raddr     = cmd.shift_rd ? idx_dec[AW-1:0] : idx_ff[AW-1:0];
      rd_key    = rd_key_raw;
      rd_val    = rd_val_raw;
      key_we    = cmd.insert | cmd.shift_wr;
      val_we    = cmd.insert | cmd.shift_wr | cmd.overwrite;
      key_wdata = cmd.shift_wr ? rd_key_raw : x_ff;
      val_wdata = cmd.shift_wr ? rd_val_raw : v_ff;
      dx_s      = {x_ff[DW-1], x_ff} - {klo_ff[DW-1], klo_ff};
      dk_s      = {kup_ff[DW-1], kup_ff} - {klo_ff[DW-1], klo_ff};
      dup_s     = {kup_ff[DW-1], kup_ff} - {x_ff[DW-1], x_ff};
      dy_s      = {vup_ff[DW-1], vup_ff} - {vlo_ff[DW-1], vlo_ff};
      dy_neg    = dy_s[DW];
      mag_s     = dy_neg ? -dy_s : dy_s;
   end

   plt_ram #(.WIDTH(DW), .DEPTH(TABLE_ENTRIES)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (idx_ff[AW-1:0]),
      .wdata (key_wdata),
      .re    (cmd.rd_cur | cmd.shift_rd),
      .raddr (raddr),
      .rdata (rd_key_raw)
   );

   plt_ram #(.WIDTH(DW), .DEPTH(TABLE_ENTRIES)) u_val_ram (
      .clock (clock),
      .we    (val_we),
      .waddr (idx_ff[AW-1:0]),
      .wdata (val_wdata),
      .re    (cmd.rd_cur | cmd.shift_rd),
      .raddr (raddr),
      .rdata (rd_val_raw)
   );

   plt_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .mag   (mag_s[DW-1:0]),
      .num   (dx_s[DW-1:0]),
      .den   (dk_s[DW-1:0]),
      .done  (div_done),
      .quot  (div_q)
   );

   // entry count is the only state that reset must clear
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.insert) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff        <= req_payload.req_type;
         x_ff           <= req_payload.key_x;
         v_ff           <= req_payload.entry_value;
         idx_ff         <= '0;
         res_y_ff       <= '0;
         res_status_ff  <= ST_OK;
         res_clamped_ff <= 1'b0;
      end
      if (cmd.set_empty) begin
         res_status_ff <= ST_EMPTY;
      end
      if (cmd.set_full) begin
         res_status_ff <= ST_FULL;
      end
      if (cmd.overwrite) begin
         res_status_ff <= ST_OVERWRITE;
      end
      if (cmd.step) begin
         klo_ff <= rd_key;
         vlo_ff <= rd_val;
         idx_ff <= idx_ff + CW'(1);
      end
      if (cmd.found_up) begin
         kup_ff <= rd_key;
         vup_ff <= rd_val;
      end
      if (cmd.first_clamp) begin
         res_y_ff       <= rd_val;
         res_clamped_ff <= 1'b1;
      end
      if (cmd.end_clamp) begin
         res_y_ff       <= vlo_ff;
         res_clamped_ff <= (x_ff != klo_ff);
      end
      if (cmd.load_shift) begin
         pos_ff <= idx_ff;
         idx_ff <= count_ff;
      end
      if (cmd.shift_wr) begin
         idx_ff <= idx_dec;
      end
      // tie goes to the upper neighbor
      if (cmd.near) begin
         res_y_ff <= (dx_s[DW-1:0] < dup_s[DW-1:0]) ? vlo_ff : vup_ff;
      end
      if (cmd.div_finish) begin
         res_y_ff <= dy_neg ? (vlo_ff - div_q) : (vlo_ff + div_q);
      end
      if (cmd.load_out) begin
         out_ff.result_y <= res_y_ff;
         out_ff.status   <= res_status_ff;
         out_ff.clamped  <= res_clamped_ff;
      end
   end

   always_comb begin
      status.kind         = kind_ff;
      status.count_zero   = (count_ff == '0);
      status.full         = (count_ff == CW'(TABLE_ENTRIES));
      status.idx_eq_count = (idx_ff == count_ff);
      status.idx_zero     = (idx_ff == '0);
      status.idx_eq_pos   = (idx_ff == pos_ff);
      status.key_gt       = (rd_key > x_ff);
      status.key_eq       = (rd_key == x_ff);
      status.div_done     = div_done;
   end

   assign rsp_payload = out_ff;

endmodule

// File: design/plt_ctrl.sv
// ----------------------------------------------------------------------------
// plt_ctrl
// Controller: sequences scan, shift, insert and divide for one item at a time.
// ----------------------------------------------------------------------------
module plt_ctrl
   import plt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.kind)
               REQ_ADD: begin
                  state_in = S_SCAN_RD;
               end
               REQ_INTERP, REQ_NEAREST: begin
                  if (status.count_zero) begin
                     cmd.set_empty = 1'b1;
                     state_in      = S_FINISH;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SCAN_RD: begin
            if (status.idx_eq_count) begin
               state_in = S_SCAN_END;
            end else begin
               cmd.rd_cur = 1'b1;
               state_in   = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (status.kind == REQ_ADD) begin
               if (status.key_eq) begin
                  cmd.overwrite = 1'b1;
                  state_in      = S_FINISH;
               end else if (status.key_gt) begin
                  if (status.full) begin
                     cmd.set_full = 1'b1;
                     state_in     = S_FINISH;
                  end else begin
                     cmd.load_shift = 1'b1;
                     state_in       = S_SHIFT_CHK;
                  end
               end else begin
                  cmd.step = 1'b1;
                  state_in = S_SCAN_RD;
               end
            end else if (status.key_gt) begin
               if (status.idx_zero) begin
                  cmd.first_clamp = 1'b1;
                  state_in        = S_FINISH;
               end else begin
                  cmd.found_up = 1'b1;
                  state_in = (status.kind == REQ_INTERP) ? S_DIV_START : S_NEAR;
               end
            end else begin
               cmd.step = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_END: begin
            if (status.kind == REQ_ADD) begin
               if (status.full) begin
                  cmd.set_full = 1'b1;
               end else begin
                  cmd.insert = 1'b1;
               end
            end else begin
               cmd.end_clamp = 1'b1;
            end
            state_in = S_FINISH;
         end
         S_SHIFT_CHK: begin
            if (status.idx_eq_pos) begin
               cmd.insert = 1'b1;
               state_in   = S_FINISH;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_CHK;
         end
         S_NEAR: begin
            cmd.near = 1'b1;
            state_in = S_FINISH;
         end
         S_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_finish = 1'b1;
               state_in       = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/piecewise_linear_table_interp.sv
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// Sorted (key, value) table with insert, linear interpolation and nearest
// lookup on signed Q16.16 numbers.
// ----------------------------------------------------------------------------
// sequence: an add scans the keys, then moves each later entry up with a read
//   and a write; a query scans up to the first key above x, and interpolation
//   then runs the bit-serial divider
// throughput: one item at a time; a result waits in the output register while
//   the next item is taken
// reset: synchronous, clears the entry count, the handshake state and the divider control only
module piecewise_linear_table_interp
   import plt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   // command and status between controller and datapath
   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // controller walks the scan, shift and divide phases
   plt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // datapath holds the memories, neighbor registers and the output register
   plt_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (ctrl_cmd),
      .req_payload (req_payload),
      .status      (dp_status),
      .rsp_payload (rsp_payload)
   );

   // a transfer on the request side always starts a busy period
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side ready right after a transfer");

   // a new key is never inserted into a full table
   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      !(ctrl_cmd.insert && dp_status.full))
      else $error("insert into full table");

   // at most one memory write kind per cycle
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl_cmd.insert, ctrl_cmd.shift_wr, ctrl_cmd.overwrite}))
      else $error("conflicting memory writes");

   // the divider runs only for interpolation queries
   a_div_interp: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.div_start |-> (dp_status.kind == REQ_INTERP))
      else $error("divider started for a non-interpolation item");

endmodule
